/* hdl/bmmmv_pkg.sv */
// Shared types and constants for the block min/max/mean/variance unit.
// Used by the front end, the block queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bmmmv_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_SAMPLES = 131072;
	localparam int COUNT_W     = 18;
	localparam int SUM_W       = 33;
	localparam int SQ_W        = 2 * SAMPLE_W;
	localparam int SQ_SUM_W    = 49;
	localparam int VAR_W       = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W      = 2;
	localparam int DIV_STEPS   = SQ_SUM_W;
	localparam int SQRT_STEPS  = VAR_W / 2;
	localparam int ITER_W      = 6;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

	// Snapshot of one finished block, handed from front to back
	typedef struct packed {
		logic [SAMPLE_W-1:0] minimum;
		logic [SAMPLE_W-1:0] maximum;
		logic [SUM_W-1:0]    sample_sum;
		logic [SQ_SUM_W-1:0] square_sum;
		logic [COUNT_W-1:0]  sample_count;
		logic                saturated;
	} block_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} queue_stat_t;

endpackage

`default_nettype wire

/* hdl/bmmmv_if.sv */
// Valid/ready channel interfaces for samples and block results.
// Depends on bmmmv_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmmmv_in_if;
	logic                          valid;
	logic                          ready;
	logic [bmmmv_pkg::SAMPLE_W-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface bmmmv_out_if;
	logic                          valid;
	logic                          ready;
	logic [bmmmv_pkg::SAMPLE_W-1:0] minimum;
	logic [bmmmv_pkg::SAMPLE_W-1:0] maximum;
	logic [bmmmv_pkg::SAMPLE_W-1:0] mean_value;
	logic [bmmmv_pkg::VAR_W-1:0]    variance;
	logic [bmmmv_pkg::SAMPLE_W-1:0] std_deviation;
	logic                          overflow;

	modport source (output valid, output minimum, output maximum, output mean_value,
		output variance, output std_deviation, output overflow, input ready);
	modport sink   (input valid, input minimum, input maximum, input mean_value,
		input variance, input std_deviation, input overflow, output ready);
endinterface

`default_nettype wire

/* hdl/bmmmv_front.sv */
// Front end: takes samples, squares them and accumulates block statistics.
// Pushes one block snapshot per last sample. Depends on bmmmv_pkg, bmmmv_if.
`timescale 1ns / 1ps
`default_nettype none

module bmmmv_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	bmmmv_in_if.sink                    samples,
	input  wire bmmmv_pkg::queue_stat_t qstat,
	output logic                        push,
	output bmmmv_pkg::block_t           push_block
);

	logic                              valid_s1;
	logic                              last_s1;
	logic [bmmmv_pkg::SAMPLE_W-1:0]    sample_s1;
	logic [bmmmv_pkg::SQ_W-1:0]        square_s1;

	logic [bmmmv_pkg::SAMPLE_W-1:0]    min_q;
	logic [bmmmv_pkg::SAMPLE_W-1:0]    max_q;
	logic [bmmmv_pkg::SUM_W-1:0]       sum_q;
	logic [bmmmv_pkg::SQ_SUM_W-1:0]    sq_sum_q;
	logic [bmmmv_pkg::COUNT_W-1:0]     count_q;
	logic                              sat_q;

	logic [bmmmv_pkg::SAMPLE_W-1:0]    masked;
	logic [bmmmv_pkg::QCNT_W:0]        pending;
	bmmmv_pkg::block_t                 nxt;

	// Take a sample only if its block snapshot is sure to find queue room
	assign pending       = {1'b0, qstat.count} + (bmmmv_pkg::QCNT_W+1)'(valid_s1 & last_s1);
	assign samples.ready = pending < (bmmmv_pkg::QCNT_W+1)'(bmmmv_pkg::QUEUE_DEPTH);
	assign masked        = samples.sample & bmmmv_pkg::SAMPLE_MASK;

	// Stage 1: register the sample and its square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			sample_s1 <= '0;
			square_s1 <= '0;
		end else begin
			valid_s1 <= samples.valid & samples.ready;
			if (samples.valid && samples.ready) begin
				last_s1   <= samples.last_sample;
				sample_s1 <= masked;
				square_s1 <= masked * masked;
			end
		end
	end

	// Next block state including the stage 1 sample
	always_comb begin
		nxt.minimum      = min_q;
		nxt.maximum      = max_q;
		nxt.sample_sum   = sum_q;
		nxt.square_sum   = sq_sum_q;
		nxt.sample_count = count_q;
		nxt.saturated    = sat_q;
		if (count_q >= bmmmv_pkg::COUNT_W'(bmmmv_pkg::MAX_SAMPLES)) begin
			nxt.saturated = 1'b1;
		end else begin
			if (count_q == '0) begin
				nxt.minimum = sample_s1;
				nxt.maximum = sample_s1;
			end else begin
				if (sample_s1 < min_q) nxt.minimum = sample_s1;
				if (sample_s1 > max_q) nxt.maximum = sample_s1;
			end
			nxt.sample_sum   = sum_q + bmmmv_pkg::SUM_W'(sample_s1);
			nxt.square_sum   = sq_sum_q + bmmmv_pkg::SQ_SUM_W'(square_s1);
			nxt.sample_count = count_q + 1'b1;
		end
	end

	assign push       = valid_s1 & last_s1;
	assign push_block = nxt;

	// Stage 2: accumulate, clear after the last sample of a block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= '0;
			max_q    <= '0;
			sum_q    <= '0;
			sq_sum_q <= '0;
			count_q  <= '0;
			sat_q    <= 1'b0;
		end else if (valid_s1) begin
			if (last_s1) begin
				min_q    <= '0;
				max_q    <= '0;
				sum_q    <= '0;
				sq_sum_q <= '0;
				count_q  <= '0;
				sat_q    <= 1'b0;
			end else begin
				min_q    <= nxt.minimum;
				max_q    <= nxt.maximum;
				sum_q    <= nxt.sample_sum;
				sq_sum_q <= nxt.square_sum;
				count_q  <= nxt.sample_count;
				sat_q    <= nxt.saturated;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bmmmv_queue.sv */
// Two-entry queue of finished block snapshots between front and back.
// Depends on bmmmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmmmv_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire bmmmv_pkg::block_t      push_block,
	input  wire logic                   pop,
	output bmmmv_pkg::block_t           head,
	output bmmmv_pkg::queue_stat_t      qstat
);

	bmmmv_pkg::block_t                 entries_q [bmmmv_pkg::QUEUE_DEPTH];
	logic                              wr_ptr_q;
	logic                              rd_ptr_q;
	logic [bmmmv_pkg::QCNT_W-1:0]      count_q;

	assign head        = entries_q[rd_ptr_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);

	// Store snapshots; the front never pushes into a full queue
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_block;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/bmmmv_back.sv */
// Back end: divides sums by count, forms variance and its square root,
// and holds the result in an output register. Depends on bmmmv_pkg, bmmmv_if.
`timescale 1ns / 1ps
`default_nettype none

module bmmmv_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bmmmv_pkg::block_t      head,
	input  wire bmmmv_pkg::queue_stat_t qstat,
	output logic                        pop,
	bmmmv_out_if.source                 results
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_SUB,
		ST_SQRT,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [bmmmv_pkg::ITER_W-1:0]      iter_q;

	logic [bmmmv_pkg::SAMPLE_W-1:0]    min_q;
	logic [bmmmv_pkg::SAMPLE_W-1:0]    max_q;
	logic                              sat_q;
	logic [bmmmv_pkg::COUNT_W-1:0]     divisor_q;
	logic [bmmmv_pkg::SQ_SUM_W-1:0]    dvd_sum_q;
	logic [bmmmv_pkg::SQ_SUM_W-1:0]    dvd_sq_q;
	logic [bmmmv_pkg::COUNT_W-1:0]     rem_sum_q;
	logic [bmmmv_pkg::COUNT_W-1:0]     rem_sq_q;
	logic [bmmmv_pkg::SAMPLE_W-1:0]    mean_q;
	logic [bmmmv_pkg::VAR_W-1:0]       msq_q;
	logic [bmmmv_pkg::VAR_W-1:0]       m2_q;
	logic [bmmmv_pkg::VAR_W-1:0]       var_q;
	logic [bmmmv_pkg::VAR_W-1:0]       rad_q;
	logic [bmmmv_pkg::VAR_W-1:0]       root_q;
	logic [bmmmv_pkg::VAR_W-1:0]       bit_q;

	logic                              out_valid_q;
	logic [bmmmv_pkg::SAMPLE_W-1:0]    out_min_q;
	logic [bmmmv_pkg::SAMPLE_W-1:0]    out_max_q;
	logic [bmmmv_pkg::SAMPLE_W-1:0]    out_mean_q;
	logic [bmmmv_pkg::VAR_W-1:0]       out_var_q;
	logic [bmmmv_pkg::SAMPLE_W-1:0]    out_sd_q;
	logic                              out_ovf_q;

	logic [bmmmv_pkg::COUNT_W:0]       rx_sum;
	logic [bmmmv_pkg::COUNT_W:0]       rx_sq;
	logic                              ge_sum;
	logic                              ge_sq;
	logic [bmmmv_pkg::COUNT_W:0]       rn_sum;
	logic [bmmmv_pkg::COUNT_W:0]       rn_sq;
	logic [bmmmv_pkg::VAR_W:0]         trial;
	logic                              take;
	logic                              out_free;
	logic                              out_load;

	assign pop      = (state_q == ST_IDLE) && !qstat.empty;
	assign out_free = !out_valid_q || results.ready;
	assign out_load = (state_q == ST_DONE) && out_free;

	// One restoring division step for both quotients
	always_comb begin
		rx_sum = {rem_sum_q, dvd_sum_q[bmmmv_pkg::SQ_SUM_W-1]};
		rx_sq  = {rem_sq_q, dvd_sq_q[bmmmv_pkg::SQ_SUM_W-1]};
		ge_sum = rx_sum >= {1'b0, divisor_q};
		ge_sq  = rx_sq >= {1'b0, divisor_q};
		rn_sum = ge_sum ? rx_sum - {1'b0, divisor_q} : rx_sum;
		rn_sq  = ge_sq ? rx_sq - {1'b0, divisor_q} : rx_sq;
	end

	// One square root step
	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = {1'b0, rad_q} >= trial;

	// Sequence division, squaring, subtraction and square root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a load, drop it after its transfer
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						min_q     <= head.minimum;
						max_q     <= head.maximum;
						sat_q     <= head.saturated;
						divisor_q <= head.sample_count;
						dvd_sum_q <= bmmmv_pkg::SQ_SUM_W'(head.sample_sum);
						dvd_sq_q  <= head.square_sum;
						rem_sum_q <= '0;
						rem_sq_q  <= '0;
						mean_q    <= '0;
						msq_q     <= '0;
						iter_q    <= bmmmv_pkg::ITER_W'(bmmmv_pkg::DIV_STEPS - 1);
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_sum_q <= rn_sum[bmmmv_pkg::COUNT_W-1:0];
					rem_sq_q  <= rn_sq[bmmmv_pkg::COUNT_W-1:0];
					dvd_sum_q <= dvd_sum_q << 1;
					dvd_sq_q  <= dvd_sq_q << 1;
					mean_q    <= {mean_q[bmmmv_pkg::SAMPLE_W-2:0], ge_sum};
					msq_q     <= {msq_q[bmmmv_pkg::VAR_W-2:0], ge_sq};
					iter_q    <= iter_q - 1'b1;
					if (iter_q == '0) state_q <= ST_MUL;
				end
				ST_MUL: begin
					m2_q    <= mean_q * mean_q;
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					var_q   <= (msq_q > m2_q) ? msq_q - m2_q : '0;
					rad_q   <= (msq_q > m2_q) ? msq_q - m2_q : '0;
					root_q  <= '0;
					bit_q   <= bmmmv_pkg::VAR_W'(1) << (bmmmv_pkg::VAR_W - 2);
					iter_q  <= bmmmv_pkg::ITER_W'(bmmmv_pkg::SQRT_STEPS - 1);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (take) begin
						rad_q  <= rad_q - trial[bmmmv_pkg::VAR_W-1:0];
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q  <= bit_q >> 2;
					iter_q <= iter_q - 1'b1;
					if (iter_q == '0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_min_q   <= min_q;
						out_max_q   <= max_q;
						out_mean_q  <= mean_q;
						out_var_q   <= var_q;
						out_sd_q    <= root_q[bmmmv_pkg::SAMPLE_W-1:0];
						out_ovf_q   <= sat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid         = out_valid_q;
	assign results.minimum       = out_min_q;
	assign results.maximum       = out_max_q;
	assign results.mean_value    = out_mean_q;
	assign results.variance      = out_var_q;
	assign results.std_deviation = out_sd_q;
	assign results.overflow      = out_ovf_q;

endmodule

`default_nettype wire

/* hdl/block_min_max_mean_variance.sv */
// Top level of the block min/max/mean/variance unit.
// Depends on bmmmv_pkg, bmmmv_if, bmmmv_front, bmmmv_queue, bmmmv_back.
//
// Usage:
//   samples: valid/ready channel of unsigned Q1.15 samples; last_sample marks
//     the final sample of a block, which is itself part of the block.
//   results: valid/ready channel with one item per block: min, max, mean,
//     variance (units of 2^-30) and standard deviation; overflow is set when
//     the block offered more than 131072 samples (only the first are used).
//   Throughput: one sample per cycle while samples.ready is high; ready drops
//     when the queue lacks room. Each block passes the back end in one load,
//     49 shared division steps for both quotients, one multiply, one subtract,
//     16 square root steps and one output load.
//   Two finished blocks can wait between front and back; when both slots are
//     taken, samples stall until the back end frees one, so very short blocks
//     run at the pace of the back end.
//   Stall: a result waits in the output register while results.ready is low;
//     the back end finishes the next block and holds it until the register
//     frees, and the front keeps taking samples as long as queue room remains.
//   Reset (arst_n low): clears the running block, the queue and the output.
`timescale 1ns / 1ps
`default_nettype none

module block_min_max_mean_variance (
	input  wire logic clk,
	input  wire logic arst_n,
	bmmmv_in_if.sink    samples,
	bmmmv_out_if.source results
);

	logic                   push;
	logic                   pop;
	bmmmv_pkg::block_t      push_block;
	bmmmv_pkg::block_t      head;
	bmmmv_pkg::queue_stat_t qstat;

	bmmmv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.qstat      (qstat),
		.push       (push),
		.push_block (push_block)
	);

	bmmmv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_block (push_block),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	bmmmv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qstat   (qstat),
		.pop     (pop),
		.results (results)
	);

endmodule

`default_nettype wire
